// ===== rtl/md5sh_pkg.sv =====
// Types, initial values and step tables for the MD5 stream hasher.
package md5sh_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD80,
        S_ZERO,
        S_LEN,
        S_COMP,
        S_ADD,
        S_OUT
    } t_state;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_MARK = 8'h80;

    // Byte position in the block at which the length field starts.
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;

    localparam logic [31:0] SINE_TAB [64] = '{
        32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
        32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
        32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
        32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
        32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
        32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
        32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
        32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
        32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
        32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
        32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
        32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
        32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
        32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
        32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
        32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
    };

    // Rotate amount, indexed by round and the low two bits of the step.
    function automatic logic [4:0] rot_amount(input logic [1:0] round, input logic [1:0] sub);
        logic [4:0] amt;
        unique case ({round, sub})
            4'd0:    amt = 5'd7;
            4'd1:    amt = 5'd12;
            4'd2:    amt = 5'd17;
            4'd3:    amt = 5'd22;
            4'd4:    amt = 5'd5;
            4'd5:    amt = 5'd9;
            4'd6:    amt = 5'd14;
            4'd7:    amt = 5'd20;
            4'd8:    amt = 5'd4;
            4'd9:    amt = 5'd11;
            4'd10:   amt = 5'd16;
            4'd11:   amt = 5'd23;
            4'd12:   amt = 5'd6;
            4'd13:   amt = 5'd10;
            4'd14:   amt = 5'd15;
            default: amt = 5'd21;
        endcase
        return amt;
    endfunction

endpackage

// ===== rtl/md5_stream_hasher.sv =====
// MD5 stream hasher: byte packing, padding sequencer and one-step-per-cycle compression.
// A byte item is taken while idle; the 64th byte of a block starts a compression
// (64 compression steps and one chaining add) that ends before the next item is taken.
// A last item runs padding (the 0x80 mark, zero bytes and the bit length, with one or
// two compressions), then offers the four digest words in turn as i_ready takes them.
// Each 64-byte block goes through the single shared step unit; no byte is taken meanwhile.
// Reset (synchronous, active low) loads the MD5 initial values and clears all counters.
module md5_stream_hasher
    import md5sh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_word_last
);

    t_state      r_state, n_state;
    t_state      r_ret, n_ret;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_total, n_total;
    logic [5:0]  r_step, n_step;
    logic [1:0]  r_out_idx, n_out_idx;

    logic [31:0] r_chain_a, r_chain_b, r_chain_c, r_chain_d;
    logic [31:0] r_wa, r_wb, r_wc, r_wd;
    logic [31:0] r_blk [16];

    logic        w_wr_en;
    logic [7:0]  w_wr_byte;
    logic        w_load_work;
    logic        w_digest_done;
    t_state      w_after;
    logic [63:0] w_bits;

    logic [1:0]  w_round;
    logic [31:0] w_f;
    logic [3:0]  w_g;
    logic [31:0] w_sum;
    logic [4:0]  w_rot;
    logic [31:0] w_rotated;

    assign w_bits = {r_total[60:0], 3'b000};

    // Sequencer: next state, buffer writes and handshakes.
    always_comb begin
        n_state       = r_state;
        n_ret         = r_ret;
        n_step        = r_step;
        n_out_idx     = r_out_idx;
        n_total       = r_total;
        w_wr_en       = 1'b0;
        w_wr_byte     = i_data_byte;
        w_after       = r_state;
        w_digest_done = 1'b0;
        o_ready       = 1'b0;
        o_valid       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    w_wr_en = i_has_byte;
                    if (i_has_byte) begin
                        n_total = r_total + 64'd1;
                    end
                    w_after = i_last ? S_PAD80 : S_IDLE;
                    n_state = w_after;
                end
            end
            S_PAD80: begin
                w_wr_en   = 1'b1;
                w_wr_byte = PAD_MARK;
                w_after   = S_ZERO;
                n_state   = w_after;
            end
            S_ZERO: begin
                if (r_fill == LEN_POS) begin
                    n_state = S_LEN;
                end else begin
                    w_wr_en   = 1'b1;
                    w_wr_byte = 8'h00;
                    w_after   = S_ZERO;
                end
            end
            S_LEN: begin
                w_wr_en   = 1'b1;
                w_wr_byte = w_bits[{r_fill[2:0], 3'b000} +: 8];
                w_after   = S_OUT;
            end
            S_COMP: begin
                n_step = r_step + 6'd1;
                if (r_step == LAST_POS) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_state = r_ret;
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_out_idx = r_out_idx + 2'd1;
                    if (r_out_idx == 2'd3) begin
                        w_digest_done = 1'b1;
                        n_total       = '0;
                        n_state       = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        // A write into the last byte of the block starts a compression.
        w_load_work = w_wr_en && (r_fill == LAST_POS);
        if (w_load_work) begin
            n_state = S_COMP;
            n_ret   = w_after;
            n_step  = '0;
        end
        n_fill = w_wr_en ? r_fill + 6'd1 : r_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_fill    <= '0;
            r_total   <= '0;
            r_step    <= '0;
            r_out_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_fill    <= n_fill;
            r_total   <= n_total;
            r_step    <= n_step;
            r_out_idx <= n_out_idx;
        end
    end

    // Block buffer: bytes are packed little-endian; the first byte of a word clears the rest.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            unique case (r_fill[1:0])
                2'd0: r_blk[r_fill[5:2]]        <= {24'h000000, w_wr_byte};
                2'd1: r_blk[r_fill[5:2]][15:8]  <= w_wr_byte;
                2'd2: r_blk[r_fill[5:2]][23:16] <= w_wr_byte;
                default: r_blk[r_fill[5:2]][31:24] <= w_wr_byte;
            endcase
        end
    end

    // Shared step unit: round function, message word select, add and rotate.
    assign w_round = r_step[5:4];

    always_comb begin
        unique case (w_round)
            2'd0: begin
                w_f = (r_wb & r_wc) | (~r_wb & r_wd);
                w_g = r_step[3:0];
            end
            2'd1: begin
                w_f = (r_wb & r_wd) | (r_wc & ~r_wd);
                w_g = r_step[3:0] * 4'd5 + 4'd1;
            end
            2'd2: begin
                w_f = r_wb ^ r_wc ^ r_wd;
                w_g = r_step[3:0] * 4'd3 + 4'd5;
            end
            default: begin
                w_f = r_wc ^ (r_wb | ~r_wd);
                w_g = r_step[3:0] * 4'd7;
            end
        endcase
    end

    assign w_sum     = r_wa + w_f + r_blk[w_g] + SINE_TAB[r_step];
    assign w_rot     = rot_amount(w_round, r_step[1:0]);
    assign w_rotated = (w_sum << w_rot) | (w_sum >> (6'd32 - {1'b0, w_rot}));

    always_ff @(posedge i_clk) begin
        if (w_load_work) begin
            r_wa <= r_chain_a;
            r_wb <= r_chain_b;
            r_wc <= r_chain_c;
            r_wd <= r_chain_d;
        end else if (r_state == S_COMP) begin
            r_wa <= r_wd;
            r_wd <= r_wc;
            r_wc <= r_wb;
            r_wb <= r_wb + w_rotated;
        end
    end

    // Chaining words; they return to the initial values once the digest is delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_digest_done) begin
            r_chain_a <= IV_A;
            r_chain_b <= IV_B;
            r_chain_c <= IV_C;
            r_chain_d <= IV_D;
        end else if (r_state == S_ADD) begin
            r_chain_a <= r_chain_a + r_wa;
            r_chain_b <= r_chain_b + r_wb;
            r_chain_c <= r_chain_c + r_wc;
            r_chain_d <= r_chain_d + r_wd;
        end
    end

    always_comb begin
        unique case (r_out_idx)
            2'd0:    o_digest_word = r_chain_a;
            2'd1:    o_digest_word = r_chain_b;
            2'd2:    o_digest_word = r_chain_c;
            default: o_digest_word = r_chain_d;
        endcase
    end

    assign o_word_index = r_out_idx;
    assign o_word_last  = (r_out_idx == 2'd3);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken while digest words are pending");

    a_comp_to_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP && r_step == LAST_POS) |=> (r_state == S_ADD))
        else $error("compression did not finish after the last step");

    a_len_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEN) |-> (r_fill[5:3] == 3'b111))
        else $error("length byte written outside the length field");

    a_digest_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_word_last) |=>
            (r_state == S_IDLE && r_fill == '0 && r_total == '0 && r_chain_a == IV_A))
        else $error("state not returned to initial values after the digest");

    a_out_block_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_fill == '0))
        else $error("digest offered with a partly filled block");

endmodule
